FILE: rtl/sisc_pkg.sv
package sisc_pkg;

   // Store geometry
   localparam int DEPTH    = 32;
   localparam int IDX_W    = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W  = $clog2(DEPTH + 1);
   localparam int TOTAL_W  = $clog2(DEPTH * (DEPTH - 1) / 2 + 1);

   // Port field widths
   localparam int DATA_W      = 32;
   localparam int POS_W       = 6;
   localparam int TOTAL_OUT_W = 11;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_DUMP   = 2'd1,
      CMD_CLEAR  = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_DUMP   = 2'd1,
      KIND_CLEAR  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_ROTATE = 2'd2
   } cell_op_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_DUMP = 1'b1
   } state_type;

   // Per-cell control from the sequencer
   typedef struct packed {
      cell_op_type op;
      logic        occ;   // cell holds a stored entry
      logic        tail;  // first free cell
      logic        wrap;  // last occupied cell
   } cell_ctrl_type;

endpackage

FILE: rtl/sorted_insert_with_shift_count_unit.sv
// Sorted insertion store: keeps up to DEPTH signed 32-bit values in ascending
// order in a row of cells, each holding one entry and comparing it with the
// incoming value in parallel. An insert or a clear is accepted and its result is
// registered at the output the cycle after; an unused command is accepted and
// gives no result. Such requests can follow back to back while the result port
// keeps up. A dump of n stored entries emits n results (one result for an empty
// store) by rotating the cell row left by one entry per cycle while the result
// port keeps up and reading the head cell; no request is accepted until the last
// entry of the dump has been loaded into the output register, and the rotation
// leaves the store in its original order. A full store refuses an insert and
// flags it.
module sorted_insert_with_shift_count_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_command,
   input  logic signed [sisc_pkg::DATA_W-1:0]    req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [1:0]                            rsp_kind,
   output logic signed [sisc_pkg::DATA_W-1:0]    rsp_entry_value,
   output logic [sisc_pkg::POS_W-1:0]            rsp_position,
   output logic [sisc_pkg::POS_W-1:0]            rsp_shifts_this_insert,
   output logic [sisc_pkg::TOTAL_OUT_W-1:0]      rsp_total_shifts,
   output logic                                  rsp_dropped_full,
   output logic                                  rsp_entry_valid,
   output logic                                  rsp_last
);
   import sisc_pkg::*;

   // Control state
   state_type            state_ff, state_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic [IDX_W-1:0]     dump_idx_ff, dump_idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Result payload
   kind_type                 kind_ff, kind_in;
   logic signed [DATA_W-1:0] value_ff, value_in;
   logic [IDX_W-1:0]         pos_ff, pos_in;
   logic [IDX_W-1:0]         shifts_ff, shifts_in;
   logic [TOTAL_W-1:0]       total_out_ff, total_out_in;
   logic                     dropped_ff, dropped_in;
   logic                     evalid_ff, evalid_in;
   logic                     last_ff, last_in;

   // Cell row
   cell_ctrl_type            ctrl [DEPTH];
   cell_op_type              cell_op;
   logic signed [DATA_W-1:0] cell_value [DEPTH];
   logic [DEPTH-1:0]         cell_gt;

   logic                     out_free;
   logic                     req_accept;
   logic [IDX_W-1:0]         ins_pos;
   logic                     any_gt;
   logic [IDX_W-1:0]         ins_shifts;
   logic                     dump_last;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE) || !out_free;
   assign req_accept = req_valid && !req_stall;

   // Per-cell control derived from the entry count
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         ctrl[i].op   = cell_op;
         ctrl[i].occ  = COUNT_W'(i) < count_ff;
         ctrl[i].tail = COUNT_W'(i) == count_ff;
         ctrl[i].wrap = COUNT_W'(i) == (count_ff - COUNT_W'(1));
      end
   end

   // The row of cells
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [DATA_W-1:0] left_v;
      logic signed [DATA_W-1:0] right_v;
      logic                     left_g;
      if (g == 0) begin : g_first
         assign left_v = '0;
         assign left_g = 1'b0;
      end else begin : g_inner
         assign left_v = cell_value[g-1];
         assign left_g = cell_gt[g-1];
      end
      if (g == DEPTH - 1) begin : g_end
         assign right_v = '0;
      end else begin : g_mid
         assign right_v = cell_value[g+1];
      end
      sisc_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl[g]),
         .new_value   (req_value),
         .left_value  (left_v),
         .left_gt     (left_g),
         .right_value (right_v),
         .head_value  (cell_value[0]),
         .value       (cell_value[g]),
         .gt          (cell_gt[g])
      );
   end

   // Landing index: the lowest cell that moves, or the tail when none moves.
   // The moving cells form one run at the top, so its start is one-hot.
   always_comb begin
      ins_pos = '0;
      any_gt  = |cell_gt;
      for (int i = 0; i < DEPTH; i++) begin
         if (cell_gt[i] && (i == 0 || !cell_gt[(i == 0) ? 0 : i - 1])) begin
            ins_pos = ins_pos | IDX_W'(i);
         end
      end
      if (!any_gt) begin
         ins_pos = count_ff[IDX_W-1:0];
      end
      ins_shifts = count_ff[IDX_W-1:0] - ins_pos;
   end

   assign dump_last = (COUNT_W'(dump_idx_ff) == (count_ff - COUNT_W'(1)));

   // Sequencer: next state, cell operation and result loading
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      dump_idx_in  = dump_idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cell_op      = CELL_HOLD;
      kind_in      = kind_ff;
      value_in     = value_ff;
      pos_in       = pos_ff;
      shifts_in    = shifts_ff;
      total_out_in = total_out_ff;
      dropped_in   = dropped_ff;
      evalid_in    = evalid_ff;
      last_in      = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (cmd_type'(req_command))
                  CMD_INSERT: begin
                     rsp_valid_in = 1'b1;
                     kind_in      = KIND_INSERT;
                     value_in     = req_value;
                     evalid_in    = 1'b1;
                     last_in      = 1'b1;
                     if (count_ff == COUNT_W'(DEPTH)) begin
                        pos_in       = '0;
                        shifts_in    = '0;
                        total_out_in = total_ff;
                        dropped_in   = 1'b1;
                     end else begin
                        cell_op      = CELL_INSERT;
                        count_in     = count_ff + COUNT_W'(1);
                        total_in     = total_ff + TOTAL_W'(ins_shifts);
                        pos_in       = ins_pos;
                        shifts_in    = ins_shifts;
                        total_out_in = total_ff + TOTAL_W'(ins_shifts);
                        dropped_in   = 1'b0;
                     end
                  end
                  CMD_DUMP: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        kind_in      = KIND_DUMP;
                        value_in     = '0;
                        pos_in       = '0;
                        shifts_in    = '0;
                        total_out_in = total_ff;
                        dropped_in   = 1'b0;
                        evalid_in    = 1'b0;
                        last_in      = 1'b1;
                     end else begin
                        state_in    = ST_DUMP;
                        dump_idx_in = '0;
                     end
                  end
                  CMD_CLEAR: begin
                     count_in     = '0;
                     total_in     = '0;
                     rsp_valid_in = 1'b1;
                     kind_in      = KIND_CLEAR;
                     value_in     = '0;
                     pos_in       = '0;
                     shifts_in    = '0;
                     total_out_in = '0;
                     dropped_in   = 1'b0;
                     evalid_in    = 1'b1;
                     last_in      = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = rsp_valid_ff && rsp_stall;
                  end
               endcase
            end
         end
         ST_DUMP: begin
            // Emit the head cell and rotate the row by one entry.
            if (out_free) begin
               cell_op      = CELL_ROTATE;
               rsp_valid_in = 1'b1;
               kind_in      = KIND_DUMP;
               value_in     = cell_value[0];
               pos_in       = dump_idx_ff;
               shifts_in    = '0;
               total_out_in = total_ff;
               dropped_in   = 1'b0;
               evalid_in    = 1'b1;
               last_in      = dump_last;
               dump_idx_in  = dump_idx_ff + IDX_W'(1);
               if (dump_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         dump_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         dump_idx_ff  <= dump_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload registers
   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      value_ff     <= value_in;
      pos_ff       <= pos_in;
      shifts_ff    <= shifts_in;
      total_out_ff <= total_out_in;
      dropped_ff   <= dropped_in;
      evalid_ff    <= evalid_in;
      last_ff      <= last_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_kind               = kind_ff;
   assign rsp_entry_value        = value_ff;
   assign rsp_position           = POS_W'(pos_ff);
   assign rsp_shifts_this_insert = POS_W'(shifts_ff);
   assign rsp_total_shifts       = TOTAL_OUT_W'(total_out_ff);
   assign rsp_dropped_full       = dropped_ff;
   assign rsp_entry_valid        = evalid_ff;
   assign rsp_last               = last_ff;

endmodule

FILE: rtl/sisc_cell.sv
module sisc_cell (
   input  logic                                  clock,
   input  sisc_pkg::cell_ctrl_type               ctrl,
   input  logic signed [sisc_pkg::DATA_W-1:0]    new_value,
   input  logic signed [sisc_pkg::DATA_W-1:0]    left_value,
   input  logic                                  left_gt,
   input  logic signed [sisc_pkg::DATA_W-1:0]    right_value,
   input  logic signed [sisc_pkg::DATA_W-1:0]    head_value,
   output logic signed [sisc_pkg::DATA_W-1:0]    value,
   output logic                                  gt
);
   import sisc_pkg::*;

   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;

   // An occupied cell holding a greater value must move right.
   assign gt = ctrl.occ && (value_ff > new_value);

   // Insert: a moving cell takes its left neighbour when that one moves too,
   // otherwise the new value lands here. Rotate: shift left, and the last
   // occupied cell takes the head entry.
   always_comb begin
      value_in = value_ff;
      case (ctrl.op)
         CELL_INSERT: begin
            if (gt || ctrl.tail) begin
               value_in = left_gt ? left_value : new_value;
            end
         end
         CELL_ROTATE: begin
            value_in = ctrl.wrap ? head_value : right_value;
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import sisc_pkg::*;

   // Command code that the block ignores.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam int CLOCK_HALF   = 6;
   localparam int RESET_CYCLES = 7;
   localparam int SETTLE       = 8;
   localparam int HOLD_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_ITEMS  = 125;

   localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

   // One result of the block, field by field.
   typedef struct packed {
      logic [1:0]               kind;
      logic signed [DATA_W-1:0] value;
      logic [POS_W-1:0]         position;
      logic [POS_W-1:0]         shifts;
      logic [TOTAL_OUT_W-1:0]   total;
      logic                     dropped;
      logic                     valid;
      logic                     last;
   } store_report_type;

   // One row of the directed table; typed rows carry their own expected result.
   typedef struct packed {
      logic [1:0]               command;
      logic signed [DATA_W-1:0] value;
      logic                     typed;
      store_report_type         want;
   } directed_row_type;

   localparam store_report_type NO_REPORT  = '0;
   localparam store_report_type EMPTY_DUMP =
      '{KIND_DUMP, 32'sd0, 6'd0, 6'd0, 11'd0, 1'b0, 1'b0, 1'b1};
   localparam store_report_type CLEAR_ACK  =
      '{KIND_CLEAR, 32'sd0, 6'd0, 6'd0, 11'd0, 1'b0, 1'b1, 1'b1};
   localparam store_report_type FIRST_ZERO =
      '{KIND_INSERT, 32'sd0, 6'd0, 6'd0, 11'd0, 1'b0, 1'b1, 1'b1};
   localparam store_report_type FIRST_MAX  =
      '{KIND_INSERT, VALUE_MAX, 6'd0, 6'd0, 11'd0, 1'b0, 1'b1, 1'b1};

   localparam int ROWS = 18;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [1:0]               req_command = CMD_INSERT;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [1:0]               rsp_kind;
   logic signed [DATA_W-1:0] rsp_entry_value;
   logic [POS_W-1:0]         rsp_position;
   logic [POS_W-1:0]         rsp_shifts_this_insert;
   logic [TOTAL_OUT_W-1:0]   rsp_total_shifts;
   logic                     rsp_dropped_full;
   logic                     rsp_entry_valid;
   logic                     rsp_last;

   // Predicted copy of the store.
   logic signed [DATA_W-1:0] sorted_copy [DEPTH];
   int                       stored_count = 0;
   int                       shift_total = 0;

   store_report_type         step_reports [$];
   store_report_type         pending_reports [$];
   directed_row_type         directed_requests [ROWS];

   int                       error_count = 0;
   int                       items_sent = 0;
   int                       cycle_count = 0;
   int                       tx_idle_pct = 0;
   int                       rx_idle_pct = 0;
   int                       rx_hold_left = 0;
   logic                     rx_hold_req = 1'b0;

   sorted_insert_with_shift_count_unit uut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_command            (req_command),
      .req_value              (req_value),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_kind               (rsp_kind),
      .rsp_entry_value        (rsp_entry_value),
      .rsp_position           (rsp_position),
      .rsp_shifts_this_insert (rsp_shifts_this_insert),
      .rsp_total_shifts       (rsp_total_shifts),
      .rsp_dropped_full       (rsp_dropped_full),
      .rsp_entry_valid        (rsp_entry_valid),
      .rsp_last               (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // Works out the results of one accepted request and updates the store copy.
   function automatic void predict_store_request(input logic [1:0] command,
                                                 input logic signed [DATA_W-1:0] value);
      int slot;
      int moved;
      step_reports.delete();
      case (command)
         CMD_INSERT: begin
            if (stored_count >= DEPTH) begin
               step_reports.push_back('{KIND_INSERT, value, 6'd0, 6'd0,
                                        TOTAL_OUT_W'(shift_total), 1'b1, 1'b1, 1'b1});
            end else begin
               // Entries strictly greater than the new value move up by one.
               slot = stored_count;
               moved = 0;
               while (slot > 0 && sorted_copy[slot-1] > value) begin
                  sorted_copy[slot] = sorted_copy[slot-1];
                  slot--;
                  moved++;
               end
               sorted_copy[slot] = value;
               stored_count++;
               shift_total += moved;
               step_reports.push_back('{KIND_INSERT, value, POS_W'(slot), POS_W'(moved),
                                        TOTAL_OUT_W'(shift_total), 1'b0, 1'b1, 1'b1});
            end
         end
         CMD_DUMP: begin
            if (stored_count == 0) begin
               step_reports.push_back('{KIND_DUMP, 32'sd0, 6'd0, 6'd0,
                                        TOTAL_OUT_W'(shift_total), 1'b0, 1'b0, 1'b1});
            end else begin
               for (int i = 0; i < stored_count; i++) begin
                  step_reports.push_back('{KIND_DUMP, sorted_copy[i], POS_W'(i), 6'd0,
                                           TOTAL_OUT_W'(shift_total), 1'b0, 1'b1,
                                           (i == stored_count - 1)});
               end
            end
         end
         CMD_CLEAR: begin
            stored_count = 0;
            shift_total = 0;
            step_reports.push_back(CLEAR_ACK);
         end
         default: begin
         end
      endcase
   endfunction

   function automatic logic signed [DATA_W-1:0] random_value();
      case ($urandom_range(0, 7))
         0:       return VALUE_MIN;
         1:       return VALUE_MAX;
         2, 3:    return $signed(DATA_W'($urandom_range(0, 6))) - 3;
         default: return $signed(DATA_W'($urandom()));
      endcase
   endfunction

   // Offers one request, waits for it to be taken and records what it should cause.
   task automatic issue(input logic [1:0] command, input logic signed [DATA_W-1:0] value,
                        input logic typed = 1'b0, input store_report_type want = NO_REPORT);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= command;
      req_value   <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_store_request(command, value);
      if (typed) begin
         pending_reports.push_back(want);
      end else begin
         foreach (step_reports[i]) pending_reports.push_back(step_reports[i]);
      end
      if (command != CMD_UNUSED) items_sent++;
   endtask

   // Sender stays quiet until every outstanding result has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Mostly well-formed fill sequences between clears, with some noise in between.
   task automatic run_phase(input int budget);
      int stop_at;
      int fill;
      logic first;
      stop_at = items_sent + budget;
      first = 1'b1;
      while (items_sent < stop_at) begin
         if (first || $urandom_range(0, 99) < 85) begin
            if (first) fill = DEPTH + 3;
            else if ($urandom_range(0, 2) == 0) fill = $urandom_range(DEPTH, DEPTH + 6);
            else fill = $urandom_range(0, DEPTH - 1);
            issue(CMD_CLEAR, random_value());
            for (int i = 0; i < fill; i++) begin
               if ($urandom_range(0, 99) < 8) issue(CMD_DUMP, random_value());
               if ($urandom_range(0, 99) < 3) issue(CMD_UNUSED, random_value());
               // The opening sequence descends so that every insert moves all entries.
               if (first && i < DEPTH) issue(CMD_INSERT, VALUE_MAX - i * 1000);
               else issue(CMD_INSERT, random_value());
            end
            issue(CMD_DUMP, random_value());
            first = 1'b0;
         end else begin
            repeat ($urandom_range(1, 6)) begin
               issue(2'($urandom_range(0, 3)), $signed(DATA_W'($urandom())));
            end
         end
      end
   endtask

   // Receiver back-pressure, with an occasional long hold-off.
   always @(posedge clock) begin
      if (rx_hold_req) begin
         rx_hold_left = HOLD_CYCLES;
         rx_hold_req = 1'b0;
      end
      if (rx_hold_left > 0) begin
         rx_hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
      end
   end

   function automatic void check_field(input string name, input longint want,
                                       input longint got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
   endfunction

   // Compares each accepted result with the oldest expectation.
   always @(posedge clock) begin
      store_report_type oldest;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reports.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result kind %0d value %0d", $time, rsp_kind,
                     rsp_entry_value);
         end else begin
            oldest = pending_reports.pop_front();
            check_field("kind", oldest.kind, rsp_kind);
            check_field("entry_value", $signed(oldest.value), rsp_entry_value);
            check_field("position", oldest.position, rsp_position);
            check_field("shifts_this_insert", oldest.shifts, rsp_shifts_this_insert);
            check_field("total_shifts", oldest.total, rsp_total_shifts);
            check_field("dropped_full", oldest.dropped, rsp_dropped_full);
            check_field("entry_valid", oldest.valid, rsp_entry_valid);
            check_field("last", oldest.last, rsp_last);
         end
      end
   end

   // Watchdog on the whole run.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb failed");
      $finish;
   end

   initial begin
      directed_requests = '{
         '{CMD_DUMP,    32'sd0,        1'b1, EMPTY_DUMP},
         '{CMD_UNUSED,  -32'sd1,       1'b0, NO_REPORT},
         '{CMD_INSERT,  32'sd0,        1'b1, FIRST_ZERO},
         '{CMD_INSERT,  VALUE_MAX,     1'b0, NO_REPORT},
         '{CMD_INSERT,  VALUE_MIN,     1'b0, NO_REPORT},
         '{CMD_INSERT,  32'sd0,        1'b0, NO_REPORT},
         '{CMD_INSERT,  -32'sd1,       1'b0, NO_REPORT},
         '{CMD_INSERT,  VALUE_MAX,     1'b0, NO_REPORT},
         '{CMD_INSERT,  VALUE_MIN,     1'b0, NO_REPORT},
         '{CMD_DUMP,    32'sd0,        1'b0, NO_REPORT},
         '{CMD_CLEAR,   32'sh12345678, 1'b1, CLEAR_ACK},
         '{CMD_DUMP,    32'sd0,        1'b1, EMPTY_DUMP},
         '{CMD_INSERT,  VALUE_MAX,     1'b1, FIRST_MAX},
         '{CMD_INSERT,  32'sh55555555, 1'b0, NO_REPORT},
         '{CMD_INSERT,  32'shaaaaaaaa, 1'b0, NO_REPORT},
         '{CMD_UNUSED,  32'sd0,        1'b0, NO_REPORT},
         '{CMD_DUMP,    -32'sd1,       1'b0, NO_REPORT},
         '{CMD_CLEAR,   32'sd0,        1'b1, CLEAR_ACK}
      };

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed table, then random traffic with a slow receiver.
      tx_idle_pct = 18;
      rx_idle_pct = 70;
      foreach (directed_requests[i]) begin
         issue(directed_requests[i].command, directed_requests[i].value,
               directed_requests[i].typed, directed_requests[i].want);
      end
      rx_hold_req = 1'b1;
      run_phase(PHASE_ITEMS);
      drain();

      // Slow sender, quick receiver.
      tx_idle_pct = 70;
      rx_idle_pct = 18;
      run_phase(PHASE_ITEMS);
      drain();

      // Full rate on both sides, with one more long hold-off.
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      rx_hold_req = 1'b1;
      run_phase(PHASE_ITEMS);
      drain();

      if (error_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
